>>> rtl/alert_suppression_table_defines.svh
// Assertion macros used by the alert suppression table checker.
`ifndef ALERT_SUPPRESSION_TABLE_DEFINES_SVH
`define ALERT_SUPPRESSION_TABLE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define AST_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("alert table check failed");

// Check a consequent in the cycle after its antecedent.
`define AST_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("alert table check failed");

`endif

>>> rtl/ast_pkg.sv
// Shared widths, constants and types of the alert suppression table.
package ast_pkg;

  localparam int KEY_W   = 32;
  localparam int DESC_W  = 16;
  localparam int TIME_W  = 64;
  localparam int COUNT_W = 32;
  localparam int SLOT_W  = 6;

  localparam logic [TIME_W-1:0] COOLDOWN_RESET = 64'd10000000000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FINISH
  } state_t;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  stamp;
    logic [COUNT_W-1:0] count;
    logic [DESC_W-1:0]  desc;
  } entry_t;

  // One result item, without its end-of-run flag
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DESC_W-1:0]  desc;
    logic [COUNT_W-1:0] occ;
    logic               summary;
    logic [SLOT_W-1:0]  slot;
  } result_t;

endpackage

>>> rtl/alert_suppression_table.sv
// Alert suppression table: an event is scanned, then decided, then sent; a tick's summaries
// leave as its scan finds expired repeated entries, the last one after the scan with last_of_run.
// One item is in work at a time and the entry memory read port scans one entry per cycle while no
// found summary waits on a stalled output. The next item is taken once the current one is through,
// sooner after a suppressed event, later under output stalls.
// Reset clears the per-entry live bits at once and sets the cooldown window to 10000000000.
module alert_suppression_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [ast_pkg::KEY_W-1:0]   alert_key,
  input  logic [ast_pkg::DESC_W-1:0]  descriptor_tag,
  input  logic [ast_pkg::TIME_W-1:0]  time_now,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ast_pkg::KEY_W-1:0]   out_key,
  output logic [ast_pkg::DESC_W-1:0]  out_descriptor,
  output logic [ast_pkg::COUNT_W-1:0] occurrences,
  output logic                        is_summary,
  output logic [ast_pkg::SLOT_W-1:0]  slot_index,
  output logic                        last_of_run,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ast_pkg::TIME_W-1:0]  cfg_data
);
  import ast_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  state_t state, state_next;

  logic [CW-1:0]      rd_idx;
  logic               dvalid;
  logic [IW-1:0]      didx;
  logic               func_q;
  logic [KEY_W-1:0]   key_q;
  logic [DESC_W-1:0]  desc_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  window;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic [TABLE_DEPTH-1:0] live;
  logic               p_valid;
  result_t            p_res;
  result_t            o_res;
  logic               out_last;

  logic               accept;
  logic               adv;
  logic               step_ok;
  logic               ren;
  logic               wen;
  logic [IW-1:0]      waddr;
  entry_t             wdata;
  entry_t             rdata;
  logic               push;
  logic               push_last;
  logic               pend_load;
  logic               pend_clear;
  result_t            pend_res;
  logic               live_set;
  logic               live_clr;
  logic [IW-1:0]      live_idx;
  logic [TIME_W-1:0]  elapsed;
  logic               in_window;
  logic               hit;
  logic               flush;
  logic               out_free;
  logic               mod_done;
  logic [IW-1:0]      mod_rem;
  logic [IW-1:0]      new_slot;

  ast_entry_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .ren   (ren),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rdata),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata)
  );

  ast_slot_mod #(
    .DEPTH (TABLE_DEPTH)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .value (time_now),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Classify the entry at the data stage
  assign elapsed   = now_q - rdata.stamp;
  assign in_window = (elapsed < window);
  assign hit       = live[didx] && (rdata.key == key_q) && in_window;
  assign flush     = live[didx] && (rdata.count > 32'd1) && !in_window;
  assign out_free  = !out_valid || !out_stall;
  assign new_slot  = free_found ? free_idx : mod_rem;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the scan, the memory port and the result hand-off
  always_comb begin
    state_next = state;
    accept     = 1'b0;
    step_ok    = 1'b1;
    adv        = 1'b0;
    ren        = 1'b0;
    wen        = 1'b0;
    waddr      = didx;
    wdata      = rdata;
    push       = 1'b0;
    push_last  = 1'b0;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    pend_res   = p_res;
    live_set   = 1'b0;
    live_clr   = 1'b0;
    live_idx   = didx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          accept     = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (dvalid) begin
          if (!func_q) begin
            if (hit) begin
              // bump the matching entry and drop the event
              wen         = 1'b1;
              wdata.count = (rdata.count == '1) ? rdata.count : rdata.count + 32'd1;
              step_ok     = 1'b0;
              state_next  = S_IDLE;
            end else if (didx == LAST_IDX) begin
              state_next = S_DECIDE;
            end
          end else begin
            if (flush) begin
              if (p_valid && !out_free) begin
                step_ok = 1'b0;
              end else begin
                push      = p_valid;
                pend_load = 1'b1;
                pend_res  = '{key: rdata.key, desc: rdata.desc, occ: rdata.count,
                              summary: 1'b1, slot: SLOT_W'(didx)};
                live_clr  = 1'b1;
              end
            end
            if (step_ok && didx == LAST_IDX) begin
              state_next = S_FINISH;
            end
          end
        end
        adv = step_ok;
        ren = step_ok && (rd_idx < DEPTH_C);
      end
      S_DECIDE: begin
        if (mod_done) begin
          // open the entry and queue the immediate send
          wen       = 1'b1;
          waddr     = new_slot;
          wdata     = '{key: key_q, stamp: now_q, count: 32'd1, desc: desc_q};
          live_set  = 1'b1;
          live_idx  = new_slot;
          pend_load = 1'b1;
          pend_res  = '{key: key_q, desc: desc_q, occ: 32'd1,
                        summary: 1'b0, slot: SLOT_W'(new_slot)};
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!p_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the read pipeline and track the first free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid     <= 1'b0;
      rd_idx     <= '0;
      free_found <= 1'b0;
    end else if (accept) begin
      dvalid     <= 1'b0;
      rd_idx     <= '0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      if (adv) begin
        if (ren) begin
          rd_idx <= rd_idx + CW'(1);
          dvalid <= 1'b1;
        end else begin
          dvalid <= 1'b0;
        end
      end
      if (dvalid && !func_q && !live[didx] && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  // Latch the item and the data-stage index
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      key_q  <= alert_key;
      desc_q <= descriptor_tag;
      now_q  <= time_now;
    end
    if (ren) begin
      didx <= rd_idx[IW-1:0];
    end
    if (state == S_SCAN && dvalid && !func_q && !live[didx] && !free_found) begin
      free_idx <= didx;
    end
  end

  // Hold the live bit of each entry
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (live_set) begin
      live[live_idx] <= 1'b1;
    end else if (live_clr) begin
      live[live_idx] <= 1'b0;
    end
  end

  // Hold the pending result until its successor or the end of the run is known
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (pend_load) begin
      p_valid <= 1'b1;
    end else if (pend_clear) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      p_res <= pend_res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      o_res    <= p_res;
      out_last <= push_last;
    end
  end

  // Cooldown window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= COOLDOWN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window <= cfg_data;
    end
  end

  // Take a window write only while no item is in work or being offered
  assign cfg_ready      = (state == S_IDLE) && !in_valid;
  assign in_stall       = (state != S_IDLE);
  assign out_key        = o_res.key;
  assign out_descriptor = o_res.desc;
  assign occurrences    = o_res.occ;
  assign is_summary     = o_res.summary;
  assign slot_index     = o_res.slot;
  assign last_of_run    = out_last;

endmodule

>>> rtl/ast_entry_mem.sv
// Entry memory: one write port, one registered read port.
module ast_entry_mem #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       ren,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output ast_pkg::entry_t            rdata,
  input  logic                       wen,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  ast_pkg::entry_t            wdata
);
  import ast_pkg::*;

  entry_t mem [DEPTH];

  // Write the entry
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the entry; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ast_slot_mod.sv
// Remainder of the event time by the table depth, eight bits per cycle.
module ast_slot_mod #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ast_pkg::TIME_W-1:0] value,
  output logic                       done,
  output logic [$clog2(DEPTH)-1:0]   rem
);
  import ast_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int RW = IW + 1;
  localparam logic [RW-1:0] DEPTH_R = RW'(DEPTH);

  logic [TIME_W-1:0] shreg;
  logic [RW-1:0]     r;
  logic [RW-1:0]     r_next;
  logic [2:0]        cnt;
  logic              busy;

  // Fold in the top byte, one bit at a time, MSB first
  always_comb begin
    r_next = r;
    for (int k = 0; k < 8; k++) begin
      r_next = {r_next[RW-2:0], shreg[TIME_W-1-k]};
      if (r_next >= DEPTH_R) begin
        r_next = r_next - DEPTH_R;
      end
    end
  end

  // Advance the byte sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Hold the value and the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      r     <= '0;
    end else if (busy) begin
      shreg <= {shreg[TIME_W-9:0], 8'd0};
      r     <= r_next;
    end
  end

  assign rem = r[IW-1:0];

endmodule

>>> rtl/ast_checker.sv
// Port-level checks of the alert suppression table and their binding.
`include "alert_suppression_table_defines.svh"

module ast_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ast_pkg::KEY_W-1:0]   out_key,
  input logic [ast_pkg::COUNT_W-1:0] occurrences,
  input logic                        is_summary,
  input logic [ast_pkg::SLOT_W-1:0]  slot_index,
  input logic                        last_of_run
);

  // A stalled result item holds
  `AST_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_key) && $stable(occurrences) && $stable(slot_index))

  // An accepted item leaves the block busy in the cycle after its acceptance
  `AST_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // An immediate send counts one and closes its run
  `AST_ASSERT_IMP(a_send_single, clk, rst, out_valid && !is_summary, occurrences == 32'd1 && last_of_run)

  // A summary reports a repeated alert
  `AST_ASSERT_IMP(a_summary_count, clk, rst, out_valid && is_summary, occurrences > 32'd1)

endmodule

bind alert_suppression_table ast_checker u_ast_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the alert suppression table.
`timescale 1ns / 1ps

module testbench;
  import ast_pkg::*;

  localparam int DEPTH = 64;
  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [TIME_W-1:0] WINDOW_DEF = 64'd10000000000;
  localparam int SETTLE_CYCLES = DEPTH + 16;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 94;
  localparam int MAX_PRINTED = 100;

  // One send as it leaves the table
  typedef struct {
    result_t body;
    logic    last;
  } alert_out_t;

  // Shadow of the table: entries, cooldown and the sends still due
  class alert_table_model;
    logic [TIME_W-1:0]  cooldown;
    logic [KEY_W-1:0]   ent_key[DEPTH];
    logic [TIME_W-1:0]  ent_stamp[DEPTH];
    logic [COUNT_W-1:0] ent_count[DEPTH];
    logic [DESC_W-1:0]  ent_desc[DEPTH];
    alert_out_t         sends_due[$];
    int                 errors;

    function new();
      cooldown = COOLDOWN_RESET;
      errors = 0;
      foreach (ent_count[i]) ent_count[i] = '0;
    endfunction

    function void set_cooldown(logic [TIME_W-1:0] w);
      cooldown = w;
    endfunction

    function int pending();
      return sends_due.size();
    endfunction

    function void push_send(int slot, logic [COUNT_W-1:0] occ, logic summ, logic last);
      alert_out_t s;
      s.body.key = ent_key[slot];
      s.body.desc = ent_desc[slot];
      s.body.occ = occ;
      s.body.summary = summ;
      s.body.slot = slot[SLOT_W-1:0];
      s.last = last;
      sends_due.push_back(s);
    endfunction

    // Note an accepted item and work out the sends it causes
    function void note_input(logic f, logic [KEY_W-1:0] k, logic [DESC_W-1:0] d,
                             logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] age;
      int slot;
      int last_idx;
      if (f == FUNC_EVENT) begin
        // Bump the first live match still inside its window
        for (int i = 0; i < DEPTH; i++) begin
          age = now - ent_stamp[i];
          if (ent_count[i] != 0 && ent_key[i] == k && age < cooldown) begin
            if (ent_count[i] != '1) ent_count[i] += 1;
            return;
          end
        end
        // Take the first free entry, else the one picked by the time
        slot = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (ent_count[i] == 0 && slot < 0) slot = i;
        end
        if (slot < 0) slot = int'(now % DEPTH);
        ent_key[slot] = k;
        ent_stamp[slot] = now;
        ent_count[slot] = 1;
        ent_desc[slot] = d;
        push_send(slot, 1, 1'b0, 1'b1);
      end else begin
        // Find the last entry to flush so the run can be closed on it
        last_idx = -1;
        for (int i = 0; i < DEPTH; i++) begin
          age = now - ent_stamp[i];
          if (ent_count[i] > 1 && age >= cooldown) last_idx = i;
        end
        for (int i = 0; i < DEPTH; i++) begin
          age = now - ent_stamp[i];
          if (ent_count[i] > 1 && age >= cooldown) begin
            push_send(i, ent_count[i], 1'b1, i == last_idx);
            ent_count[i] = '0;
          end
        end
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Compare one accepted send against the oldest one due
    task check_result(alert_out_t got);
      alert_out_t want;
      if (sends_due.size() == 0) begin
        report_mismatch($sformatf("unexpected send: slot %0d key %h",
                                  got.body.slot, got.body.key));
      end else begin
        want = sends_due.pop_front();
        if (got.body.key !== want.body.key)
          report_mismatch($sformatf("out_key %h, want %h", got.body.key, want.body.key));
        if (got.body.desc !== want.body.desc)
          report_mismatch($sformatf("out_descriptor %h, want %h",
                                    got.body.desc, want.body.desc));
        if (got.body.occ !== want.body.occ)
          report_mismatch($sformatf("occurrences %0d, want %0d",
                                    got.body.occ, want.body.occ));
        if (got.body.summary !== want.body.summary)
          report_mismatch($sformatf("is_summary %b, want %b",
                                    got.body.summary, want.body.summary));
        if (got.body.slot !== want.body.slot)
          report_mismatch($sformatf("slot_index %0d, want %0d",
                                    got.body.slot, want.body.slot));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_of_run %b, want %b", got.last, want.last));
      end
    endtask

    task check_leftover();
      if (sends_due.size() != 0)
        report_mismatch($sformatf("%0d sends never arrived", sends_due.size()));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                func = FUNC_EVENT;
  logic [KEY_W-1:0]    alert_key = '0;
  logic [DESC_W-1:0]   descriptor_tag = '0;
  logic [TIME_W-1:0]   time_now = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KEY_W-1:0]    out_key;
  logic [DESC_W-1:0]   out_descriptor;
  logic [COUNT_W-1:0]  occurrences;
  logic                is_summary;
  logic [SLOT_W-1:0]   slot_index;
  logic                last_of_run;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TIME_W-1:0]   cfg_data = '0;

  alert_table_model    table_model;
  int                  sender_idle_pct = 38;
  int                  recv_idle_pct = 51;
  int                  quiet_cycles = 0;
  logic [KEY_W-1:0]    key_pool[16];
  logic [TIME_W-1:0]   clock_ns;

  alert_suppression_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .alert_key      (alert_key),
    .descriptor_tag (descriptor_tag),
    .time_now       (time_now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key        (out_key),
    .out_descriptor (out_descriptor),
    .occurrences    (occurrences),
    .is_summary     (is_summary),
    .slot_index     (slot_index),
    .last_of_run    (last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Check every accepted send
  always @(posedge clk) begin
    alert_out_t got;
    if (!rst && out_valid && !out_stall) begin
      got.body.key = out_key;
      got.body.desc = out_descriptor;
      got.body.occ = occurrences;
      got.body.summary = is_summary;
      got.body.slot = slot_index;
      got.last = last_of_run;
      table_model.check_result(got);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one item, idling at random first, and hold it until accepted
  task automatic send_item(input logic f, input logic [KEY_W-1:0] k,
                           input logic [DESC_W-1:0] d, input logic [TIME_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    alert_key = k;
    descriptor_tag = d;
    time_now = t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_model.note_input(f, k, d, t);
  endtask

  // Hold the input side until every due send has come
  task automatic wait_sends_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (table_model.pending() != 0) @(negedge clk);
  endtask

  task automatic write_cooldown(input logic [TIME_W-1:0] w);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    table_model.set_cooldown(w);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Advance the time mostly by fractions of the window, sometimes to about one window on, sometimes jump
  function automatic logic [TIME_W-1:0] advance_clock(logic [TIME_W-1:0] t,
                                                       logic [TIME_W-1:0] w);
    logic [TIME_W-1:0] span;
    int r;
    r = $urandom_range(0, 99);
    span = (w < 8) ? 64'd3 : (w >> 2) + 1;
    if (r < 4) return {$urandom, $urandom};
    if (r < 14) return t + w - 1 + $urandom_range(0, 2);
    return t + ({$urandom, $urandom} % span);
  endfunction

  initial begin
    logic [TIME_W-1:0] windows[PHASES];
    logic [KEY_W-1:0]  k;
    logic              is_tick;

    table_model = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = $urandom;
    windows[0] = WINDOW_DEF;
    windows[1] = 64'd1;
    windows[2] = TIME_MAX;
    windows[3] = 64'd1000;
    windows[4] = 64'd1 + {$urandom_range(0, 15), $urandom};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: window edges, wrap of time, empty and multi-entry ticks
    send_item(FUNC_EVENT, 32'h0, 16'h0, 64'd0);
    send_item(FUNC_EVENT, 32'h0, 16'hFFFF, 64'd5);
    send_item(FUNC_EVENT, 32'h0, 16'h1234, WINDOW_DEF - 1);
    send_item(FUNC_TICK, '1, '1, WINDOW_DEF - 1);
    send_item(FUNC_TICK, '0, '0, WINDOW_DEF);
    send_item(FUNC_EVENT, 32'hFFFF_FFFF, 16'hFFFF, WINDOW_DEF);
    send_item(FUNC_EVENT, 32'hFFFF_FFFF, 16'h00FF, 2 * WINDOW_DEF);
    send_item(FUNC_EVENT, 32'hFFFF_FFFF, 16'h0, 2 * WINDOW_DEF + 1);
    send_item(FUNC_EVENT, 32'hFFFF_FFFF, 16'h0, 2 * WINDOW_DEF + 2);
    send_item(FUNC_EVENT, 32'h1234_5678, 16'hA5A5, TIME_MAX);
    send_item(FUNC_EVENT, 32'h1234_5678, 16'h5A5A, 64'd0);
    send_item(FUNC_TICK, '0, '0, TIME_MAX);
    send_item(FUNC_TICK, '1, '1, WINDOW_DEF - 1);
    for (int i = 0; i < 3; i++) begin
      send_item(FUNC_EVENT, 32'hC0DE_0000 + i, 16'(16'h0100 + i), 64'd1000000000000);
      send_item(FUNC_EVENT, 32'hC0DE_0000 + i, 16'h0, 64'd1000000000001);
    end
    clock_ns = 64'd1000000000000 + WINDOW_DEF;
    send_item(FUNC_TICK, 32'h5555_AAAA, 16'hAA55, clock_ns);

    // Random phases, one cooldown setting each
    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        sender_idle_pct = 51;
        recv_idle_pct = 38;
      end else if (p == 4) begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_sends_drained();
      repeat (SETTLE_CYCLES) @(negedge clk);
      write_cooldown(windows[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) wait_sends_drained();
        is_tick = ($urandom_range(0, 99) < 20);
        k = ($urandom_range(0, 99) < 65) ? key_pool[$urandom_range(0, 15)] : $urandom;
        clock_ns = advance_clock(clock_ns, windows[p]);
        send_item(is_tick ? FUNC_TICK : FUNC_EVENT, k, 16'($urandom), clock_ns);
      end
    end

    // Drain, then leave room for any stray send
    wait_sends_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    table_model.check_leftover();
    if (table_model.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
